>>> rtl/pcm_sample_format_converter_unit_macros.svh
// ----------------------------------------------------------------------------
// pcm_sample_format_converter_unit_macros.svh
// Assertion macros shared by the PCM format converter RTL.
// ----------------------------------------------------------------------------
`ifndef PCM_SAMPLE_FORMAT_CONVERTER_UNIT_MACROS_SVH
`define PCM_SAMPLE_FORMAT_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PCM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pcm_fmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_fmt_pkg
// Types, constants and helper functions shared by the PCM format converter.
// ----------------------------------------------------------------------------
package pcm_fmt_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int BITS_W      = 5;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int NARROW_BITS = 8;
    localparam int MAX_STEP    = 16;
    localparam int STEP_W      = $clog2(MAX_STEP + 1);
    localparam int PHASE_W     = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SCALE_ROWS  = 64;

    localparam logic [7:0]          BIAS8  = 8'h80;
    localparam logic [SAMPLE_W-1:0] BIAS16 = 16'h8000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_BITS   = 3'd0,
        CFG_OUTPUT_BITS   = 3'd1,
        CFG_SOURCE_SIGNED = 3'd2,
        CFG_OUTPUT_SIGNED = 3'd3,
        CFG_SAMPLE_STEP   = 3'd4,
        CFG_SWAP_PAIRS    = 3'd5
    } t_cfg_idx;

    // What the back end does with a kept element
    typedef enum logic [1:0] {
        CMD_SINGLE = 2'd0,
        CMD_HOLD   = 2'd1,
        CMD_PAIR   = 2'd2,
        CMD_BAD    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [SAMPLE_W-1:0] raw;
        t_cmd                cmd;
    } t_entry;

    // Configuration as used by the datapath: bit counts and step already clamped
    typedef struct packed {
        logic [BITS_W-1:0]   src_bits;
        logic [BITS_W-1:0]   out_bits;
        logic                src_signed;
        logic                out_signed;
        logic [STEP_W-1:0]   step;
        logic                swap;
        logic [SAMPLE_W-1:0] scale;
    } t_cfg;

    typedef logic [SAMPLE_W-1:0] t_scale_tab [SCALE_ROWS];

    // (2^o-1)/(2^i-1) has ones at bit o-i, o-2i, ... down to o mod i
    function automatic t_scale_tab build_scale_tab();
        t_scale_tab          tab;
        logic [SAMPLE_W-1:0] v;
        int                  pos;
        for (int i = 1; i <= NARROW_BITS; i++) begin
            for (int o = NARROW_BITS + 1; o <= SAMPLE_W; o++) begin
                v   = '0;
                pos = o - i;
                for (int k = 0; k < SAMPLE_W; k++) begin
                    if (pos >= 0) begin
                        v = v | (SAMPLE_W'(1) << pos);
                    end
                    pos = pos - i;
                end
                tab[(i - 1) * NARROW_BITS + (o - NARROW_BITS - 1)] = v;
            end
        end
        return tab;
    endfunction

    localparam t_scale_tab SCALE_TAB = build_scale_tab();

    function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] b);
        logic [BITS_W-1:0] r;
        if (b == '0) begin
            r = BITS_W'(1);
        end else if (b > BITS_W'(SAMPLE_W)) begin
            r = BITS_W'(SAMPLE_W);
        end else begin
            r = b;
        end
        return r;
    endfunction

    function automatic logic [STEP_W-1:0] clamp_step(input logic [CFG_DATA_W-1:0] s);
        logic [STEP_W-1:0] r;
        if (s == '0) begin
            r = STEP_W'(1);
        end else if (int'(s) > MAX_STEP) begin
            r = STEP_W'(MAX_STEP);
        end else begin
            r = STEP_W'(s);
        end
        return r;
    endfunction

    // Scale factor for clamped bit counts; only the narrow-to-wide case is used
    function automatic logic [SAMPLE_W-1:0] scale_of(input logic [BITS_W-1:0] src,
                                                      input logic [BITS_W-1:0] dst);
        logic [BITS_W-1:0]   sm;
        logic [BITS_W-1:0]   om;
        logic [SAMPLE_W-1:0] r;
        sm = src - BITS_W'(1);
        om = dst - BITS_W'(NARROW_BITS + 1);
        if ((src <= BITS_W'(NARROW_BITS)) && (dst > BITS_W'(NARROW_BITS))) begin
            r = SCALE_TAB[{sm[2:0], om[2:0]}];
        end else begin
            r = SAMPLE_W'(1);
        end
        return r;
    endfunction

endpackage

>>> rtl/pcm_fmt_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_fmt_cfg
// Configuration registers, stored clamped, with the scale factor kept current.
// ----------------------------------------------------------------------------
module pcm_fmt_cfg import pcm_fmt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Merge a write into the current settings and recompute the scale
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOURCE_BITS:   n_cfg.src_bits   = clamp_bits(i_cfg_data);
                CFG_OUTPUT_BITS:   n_cfg.out_bits   = clamp_bits(i_cfg_data);
                CFG_SOURCE_SIGNED: n_cfg.src_signed = i_cfg_data[0];
                CFG_OUTPUT_SIGNED: n_cfg.out_signed = i_cfg_data[0];
                CFG_SAMPLE_STEP:   n_cfg.step       = clamp_step(i_cfg_data);
                CFG_SWAP_PAIRS:    n_cfg.swap       = i_cfg_data[0];
                default: ;
            endcase
        end
        n_cfg.scale = scale_of(n_cfg.src_bits, n_cfg.out_bits);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_bits   <= BITS_W'(SAMPLE_W);
            r_cfg.out_bits   <= BITS_W'(SAMPLE_W);
            r_cfg.src_signed <= 1'b1;
            r_cfg.out_signed <= 1'b1;
            r_cfg.step       <= STEP_W'(1);
            r_cfg.swap       <= 1'b0;
            r_cfg.scale      <= SAMPLE_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/pcm_fmt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_fmt_front
// Accepts source elements, applies the decimation step, tracks pairing and
// classifies each kept element into a command for the back end.
// ----------------------------------------------------------------------------
`include "pcm_sample_format_converter_unit_macros.svh"

module pcm_fmt_front import pcm_fmt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_valid,
    input  logic [SAMPLE_W-1:0] i_raw_sample,
    input  logic                i_last_in_block,
    input  logic                i_q_full,
    output logic                o_stall,
    output logic                o_push,
    output t_entry              o_entry
);

    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    logic               r_held;
    logic               n_held;

    logic               accept;
    logic               keep;
    logic               bad;
    logic [PHASE_W:0]   phase_inc;
    t_cmd               cmd;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign keep    = (r_phase == '0);
    assign bad     = (i_cfg.src_bits > BITS_W'(NARROW_BITS)) &&
                     (i_cfg.out_bits <= BITS_W'(NARROW_BITS));

    // Classify a kept element
    always_comb begin
        if (bad) begin
            cmd = CMD_BAD;
        end else if (!i_cfg.swap) begin
            cmd = CMD_SINGLE;
        end else if (!r_held) begin
            cmd = CMD_HOLD;
        end else begin
            cmd = CMD_PAIR;
        end
    end

    assign o_push = accept && keep;

    always_comb begin
        o_entry.raw = i_raw_sample;
        o_entry.cmd = cmd;
    end

    // Advance the step phase and pairing state on each transfer
    assign phase_inc = (PHASE_W + 1)'(r_phase) + (PHASE_W + 1)'(1);

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        if (accept) begin
            if (phase_inc >= i_cfg.step) begin
                n_phase = '0;
            end else begin
                n_phase = phase_inc[PHASE_W-1:0];
            end
            if (keep && !bad && i_cfg.swap) begin
                n_held = !r_held;
            end
            // block end restarts the phase and drops an unpaired sample
            if (i_last_in_block) begin
                n_phase = '0;
                n_held  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_held  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    `PCM_ASSERT_NEXT(a_block_end_restart, accept && i_last_in_block, (r_phase == '0) && !r_held, "block end must restart phase and drop held sample")
    `PCM_ASSERT_NEXT(a_pair_clears_held, o_push && (o_entry.cmd == CMD_PAIR), !r_held, "pair must consume the held sample")
    `PCM_ASSERT_NEXT(a_hold_sets_held, o_push && (o_entry.cmd == CMD_HOLD) && !i_last_in_block, r_held, "hold must mark a sample as held")

endmodule

>>> rtl/pcm_fmt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_fmt_queue
// Short FIFO of classified elements between the front and back ends.
// ----------------------------------------------------------------------------
module pcm_fmt_queue import pcm_fmt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_valid,
    output logic   o_full
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_entry = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                            r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                            r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/pcm_fmt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_fmt_back
// Converts queued elements to the output format, resolves swapped pairs and
// drives the result channel from an output register.
// ----------------------------------------------------------------------------
`include "pcm_sample_format_converter_unit_macros.svh"

module pcm_fmt_back import pcm_fmt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_q_valid,
    input  t_entry              i_q_entry,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SAMPLE_W-1:0] o_out_sample,
    output logic                o_bad_mode,
    output logic                o_last_of_run
);

    // conversion stage
    logic                r_cv_valid;
    t_cmd                r_cv_cmd;
    logic [SAMPLE_W-1:0] r_cv_value;

    // pairing and output stage
    logic [SAMPLE_W-1:0] r_held;
    logic                r_second;
    logic                n_second;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic                r_out_bad;
    logic                r_out_last;

    logic                flip;
    logic                to_uns;
    logic                to_sig;
    logic                narrow_src;
    logic                wide_out;
    logic [7:0]          src_byte;
    logic [7:0]          mul_in;
    logic [23:0]         product;
    logic [SAMPLE_W-1:0] offset;
    logic [SAMPLE_W-1:0] scaled;
    logic [SAMPLE_W-1:0] wide_v;
    logic [BITS_W-1:0]   shift_full;
    logic [2:0]          shift;
    logic [SAMPLE_W-1:0] wide_res;
    logic [SAMPLE_W-1:0] conv;

    logic                out_free;
    logic                out_load;
    logic                cv_done;
    logic                cv_take;
    logic [SAMPLE_W-1:0] ld_sample;
    logic                ld_bad;
    logic                ld_last;

    // Convert the element at the head of the queue
    assign flip       = i_cfg.src_signed ^ i_cfg.out_signed;
    assign to_uns     = i_cfg.src_signed && !i_cfg.out_signed;
    assign to_sig     = !i_cfg.src_signed && i_cfg.out_signed;
    assign narrow_src = (i_cfg.src_bits <= BITS_W'(NARROW_BITS));
    assign wide_out   = (i_cfg.out_bits > BITS_W'(NARROW_BITS));
    assign src_byte   = i_q_entry.raw[7:0];
    assign mul_in     = to_uns ? (src_byte ^ BIAS8) : src_byte;
    assign product    = 24'(mul_in) * 24'(i_cfg.scale);
    assign offset     = SAMPLE_W'(1) << (i_cfg.out_bits - BITS_W'(1));
    assign scaled     = to_sig ? (product[SAMPLE_W-1:0] - offset) : product[SAMPLE_W-1:0];
    assign wide_v     = flip ? (i_q_entry.raw ^ BIAS16) : i_q_entry.raw;
    assign shift_full = BITS_W'(SAMPLE_W) - i_cfg.out_bits;
    assign shift      = shift_full[2:0];
    assign wide_res   = i_cfg.out_signed ? $unsigned($signed(wide_v) >>> shift) :
                        (wide_v >> shift);

    always_comb begin
        if (narrow_src && wide_out) begin
            conv = scaled;
        end else if (narrow_src) begin
            conv = {8'h00, (flip ? (src_byte ^ BIAS8) : src_byte)};
        end else begin
            conv = wide_res;
        end
    end

    // Decide what the converted element sends to the output register
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        out_load  = 1'b0;
        cv_done   = 1'b0;
        n_second  = r_second;
        ld_sample = r_cv_value;
        ld_bad    = 1'b0;
        ld_last   = 1'b1;
        if (r_cv_valid) begin
            case (r_cv_cmd)
                CMD_HOLD: begin
                    cv_done = 1'b1;
                end
                CMD_SINGLE: begin
                    if (out_free) begin
                        out_load = 1'b1;
                        cv_done  = 1'b1;
                    end
                end
                CMD_BAD: begin
                    if (out_free) begin
                        out_load  = 1'b1;
                        cv_done   = 1'b1;
                        ld_sample = '0;
                        ld_bad    = 1'b1;
                    end
                end
                CMD_PAIR: begin
                    // newer sample first, then the held one closes the run
                    if (out_free) begin
                        out_load = 1'b1;
                        if (!r_second) begin
                            ld_last  = 1'b0;
                            n_second = 1'b1;
                        end else begin
                            ld_sample = r_held;
                            n_second  = 1'b0;
                            cv_done   = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign cv_take = !r_cv_valid || cv_done;
    assign o_pop   = i_q_valid && cv_take;

    // Conversion stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv_valid <= 1'b0;
        end else if (cv_take) begin
            r_cv_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cv_cmd   <= i_q_entry.cmd;
            r_cv_value <= conv;
        end
    end

    // Hold the first sample of a swapped pair
    always_ff @(posedge i_clk) begin
        if (r_cv_valid && (r_cv_cmd == CMD_HOLD)) begin
            r_held <= r_cv_value;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            r_second <= n_second;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sample <= ld_sample;
            r_out_bad    <= ld_bad;
            r_out_last   <= ld_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_sample  = r_out_sample;
    assign o_bad_mode    = r_out_bad;
    assign o_last_of_run = r_out_last;

    `PCM_ASSERT_SAME(a_bad_is_final_zero, o_valid && o_bad_mode, o_last_of_run && (o_out_sample == '0), "bad-mode result must be a single zero result")
    `PCM_ASSERT_SAME(a_second_only_in_pair, r_second, r_cv_valid && (r_cv_cmd == CMD_PAIR), "second-half flag outside a pair")
    `PCM_ASSERT_NEXT(a_pair_first_then_second, out_load && (r_cv_cmd == CMD_PAIR) && !r_second, r_second && r_cv_valid, "pair must go on to its second result")

endmodule

>>> rtl/pcm_sample_format_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_sample_format_converter_unit
// Converts a stream of PCM source elements to the output sample format.
// One element can be taken every clock cycle while the queue has room. A
// kept element's result passes through the queue, the conversion stage
// register and the output register when the back end is free. Skipped
// elements and the first half of a pair produce no result. Without pair
// swapping, with a free output, the back end retires one element per cycle.
// With pair swapping the conversion stage keeps the pair's second element
// until both of its results are sent, so a long run of swapped pairs falls
// below one element per cycle; the four-entry queue between front and back
// end absorbs short bursts and the input stalls once it is full. At most
// one result leaves per cycle. Configuration is written through the plain
// write port; the user must write it only while the block is idle, which
// the block itself does not enforce. There is no startup sweep after reset.
// ----------------------------------------------------------------------------
module pcm_sample_format_converter_unit import pcm_fmt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // source elements
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [SAMPLE_W-1:0]   i_raw_sample,
    input  logic                  i_last_in_block,
    // results
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [SAMPLE_W-1:0]   o_out_sample,
    output logic                  o_bad_mode,
    output logic                  o_last_of_run,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg   cfg;
    logic   q_full;
    logic   q_push;
    t_entry q_in;
    logic   q_pop;
    logic   q_valid;
    t_entry q_out;

    pcm_fmt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pcm_fmt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (i_valid),
        .i_raw_sample    (i_raw_sample),
        .i_last_in_block (i_last_in_block),
        .i_q_full        (q_full),
        .o_stall         (o_stall),
        .o_push          (q_push),
        .o_entry         (q_in)
    );

    pcm_fmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    pcm_fmt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_q_valid     (q_valid),
        .i_q_entry     (q_out),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_sample  (o_out_sample),
        .o_bad_mode    (o_bad_mode),
        .o_last_of_run (o_last_of_run)
    );

endmodule

>>> verif/tb_pcm_sample_format_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcm_sample_format_converter_unit
// Drives PCM source elements into the converter, predicts every result from
// a behavioral copy of the conversion, step and pair-swap logic, and checks
// each output transfer in order. Directed cases cover the format modes,
// clamped fields, the unsupported mode, pair swapping and held samples;
// random blocks then run under three idling mixes and a long output stall.
// ----------------------------------------------------------------------------
module tb_pcm_sample_format_converter_unit;
    import pcm_fmt_pkg::*;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                bad;
        logic                last;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [SAMPLE_W-1:0]   i_raw_sample;
    logic                  i_last_in_block;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [SAMPLE_W-1:0]   o_out_sample;
    logic                  o_bad_mode;
    logic                  o_last_of_run;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predictor copy of the format registers and the stream state
    logic [CFG_DATA_W-1:0] fmt_src_bits;
    logic [CFG_DATA_W-1:0] fmt_out_bits;
    logic                  fmt_src_signed;
    logic                  fmt_out_signed;
    logic [CFG_DATA_W-1:0] fmt_step;
    logic                  fmt_swap;
    int                    step_pos;
    logic [SAMPLE_W-1:0]   held_sample;
    logic                  held_ok;

    t_result expected_results[$];
    int      err_count    = 0;
    int      src_idle_pct = 0;
    int      rx_idle_pct  = 0;
    int      hold_left    = 0;

    pcm_sample_format_converter_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_raw_sample    (i_raw_sample),
        .i_last_in_block (i_last_in_block),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_sample    (o_out_sample),
        .o_bad_mode      (o_bad_mode),
        .o_last_of_run   (o_last_of_run),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic int eff_bits(input logic [CFG_DATA_W-1:0] b);
        if (b == 0) return 1;
        if (b > SAMPLE_W) return SAMPLE_W;
        return int'(b);
    endfunction

    function automatic logic [SAMPLE_W-1:0] convert_sample(input logic [SAMPLE_W-1:0] raw);
        int                  ib;
        int                  ob;
        int                  sh;
        logic                to_uns;
        logic                to_sig;
        logic [31:0]         scl;
        logic [31:0]         b;
        logic [SAMPLE_W-1:0] v;
        ib     = eff_bits(fmt_src_bits);
        ob     = eff_bits(fmt_out_bits);
        to_uns = fmt_src_signed && !fmt_out_signed;
        to_sig = !fmt_src_signed && fmt_out_signed;
        if (ib <= NARROW_BITS && ob > NARROW_BITS) begin
            // Scale narrow source up to the wide output range
            scl = ((32'd1 << ob) - 32'd1) / ((32'd1 << ib) - 32'd1);
            b   = {24'd0, raw[7:0]};
            if (to_uns) begin
                b = b ^ {24'd0, BIAS8};
            end
            if (to_sig) begin
                v = SAMPLE_W'(b * scl - ((32'd1 << ob) >> 1));
            end else begin
                v = SAMPLE_W'(b * scl);
            end
        end else if (ib <= NARROW_BITS) begin
            v = {8'h00, (to_uns || to_sig) ? (raw[7:0] ^ BIAS8) : raw[7:0]};
        end else begin
            // Wide to wide: flip bias, then shift down to the output width
            v = raw;
            if (to_uns || to_sig) begin
                v = v ^ BIAS16;
            end
            sh = SAMPLE_W - ob;
            if (ob < SAMPLE_W) begin
                if (fmt_out_signed && v[SAMPLE_W-1]) begin
                    v = ~((~v) >> sh);
                end else begin
                    v = v >> sh;
                end
            end
        end
        return v;
    endfunction

    function automatic void predict_element(input logic [SAMPLE_W-1:0] raw,
                                            input logic last_flag);
        int                  st;
        logic [SAMPLE_W-1:0] v;
        st = (fmt_step == 0) ? 1 : ((fmt_step > MAX_STEP) ? MAX_STEP : int'(fmt_step));
        if (step_pos == 0) begin
            if (eff_bits(fmt_src_bits) > NARROW_BITS && eff_bits(fmt_out_bits) <= NARROW_BITS)
            begin
                expected_results.push_back('{'0, 1'b1, 1'b1});
            end else begin
                v = convert_sample(raw);
                if (!fmt_swap) begin
                    expected_results.push_back('{v, 1'b0, 1'b1});
                end else if (!held_ok) begin
                    held_sample = v;
                    held_ok     = 1'b1;
                end else begin
                    expected_results.push_back('{v, 1'b0, 1'b0});
                    expected_results.push_back('{held_sample, 1'b0, 1'b1});
                    held_ok     = 1'b0;
                    held_sample = '0;
                end
            end
        end
        step_pos = step_pos + 1;
        if (step_pos >= st) begin
            step_pos = 0;
        end
        // Block end restarts the step and drops an unpaired sample
        if (last_flag) begin
            step_pos    = 0;
            held_ok     = 1'b0;
            held_sample = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stall plus an optional long hold-off
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    task automatic note_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
        err_count++;
    endtask

    // Compare each output transfer with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                note_mismatch("unexpected result", o_out_sample, '0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_sample !== want.sample) begin
                    note_mismatch("out_sample", o_out_sample, want.sample);
                end
                if (o_bad_mode !== want.bad) begin
                    note_mismatch("bad_mode", SAMPLE_W'(o_bad_mode), SAMPLE_W'(want.bad));
                end
                if (o_last_of_run !== want.last) begin
                    note_mismatch("last_of_run", SAMPLE_W'(o_last_of_run), SAMPLE_W'(want.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------
    task automatic send_elem(input logic [SAMPLE_W-1:0] raw, input logic last_flag);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_raw_sample    <= raw;
        i_last_in_block <= last_flag;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        predict_element(raw, last_flag);
    endtask

    // Drop valid, wait out every expected result and the pipeline tail
    task automatic drain_stream();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_SOURCE_BITS:   fmt_src_bits   = val;
            CFG_OUTPUT_BITS:   fmt_out_bits   = val;
            CFG_SOURCE_SIGNED: fmt_src_signed = val[0];
            CFG_OUTPUT_SIGNED: fmt_out_signed = val[0];
            CFG_SAMPLE_STEP:   fmt_step       = val;
            CFG_SWAP_PAIRS:    fmt_swap       = val[0];
            default: ;
        endcase
    endtask

    task automatic set_format(input logic [CFG_DATA_W-1:0] src_bits,
                              input logic [CFG_DATA_W-1:0] out_bits,
                              input logic src_sgn, input logic out_sgn,
                              input logic [CFG_DATA_W-1:0] step, input logic swap);
        drain_stream();
        write_reg(CFG_SOURCE_BITS, src_bits);
        write_reg(CFG_OUTPUT_BITS, out_bits);
        write_reg(CFG_SOURCE_SIGNED, CFG_DATA_W'(src_sgn));
        write_reg(CFG_OUTPUT_SIGNED, CFG_DATA_W'(out_sgn));
        write_reg(CFG_SAMPLE_STEP, step);
        write_reg(CFG_SWAP_PAIRS, CFG_DATA_W'(swap));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_elem(16'h0000, 1'b0);
        send_elem(16'hFFFF, 1'b0);
        send_elem(16'h8000, 1'b1);
    endtask

    task automatic test_narrow_to_wide();
        // signed to unsigned, unsigned to signed, unbiased
        set_format(5'd8, 5'd16, 1'b1, 1'b0, 5'd1, 1'b0);
        send_elem(16'hA580, 1'b0);
        send_elem(16'h00FF, 1'b0);
        set_format(5'd4, 5'd12, 1'b0, 1'b1, 5'd1, 1'b0);
        send_elem(16'h000F, 1'b0);
        send_elem(16'hFF00, 1'b0);
        set_format(5'd8, 5'd9, 1'b1, 1'b1, 5'd1, 1'b0);
        send_elem(16'h5A7F, 1'b1);
    endtask

    task automatic test_narrow_to_narrow();
        set_format(5'd8, 5'd8, 1'b0, 1'b1, 5'd1, 1'b0);
        send_elem(16'hFF7F, 1'b0);
        send_elem(16'h0080, 1'b1);
    endtask

    task automatic test_wide_shift();
        // arithmetic shift for signed output, logical for unsigned
        set_format(5'd16, 5'd12, 1'b1, 1'b1, 5'd1, 1'b0);
        send_elem(16'h8001, 1'b0);
        set_format(5'd12, 5'd9, 1'b1, 1'b0, 5'd1, 1'b0);
        send_elem(16'h7FFF, 1'b1);
    endtask

    task automatic test_clamped_fields();
        // zero source bits act as one, oversize output bits as sixteen
        set_format(5'd0, 5'd31, 1'b0, 1'b1, 5'd0, 1'b0);
        send_elem(16'h0001, 1'b0);
        // oversize step acts as the largest step: keep, skip, restart at block end
        set_format(5'd16, 5'd16, 1'b0, 1'b0, 5'd31, 1'b0);
        send_elem(16'h1234, 1'b0);
        send_elem(16'h4321, 1'b1);
        send_elem(16'hBEEF, 1'b1);
    endtask

    task automatic test_bad_mode();
        set_format(5'd16, 5'd8, 1'b1, 1'b0, 5'd1, 1'b1);
        send_elem(16'hFFFF, 1'b0);
        send_elem(16'h0000, 1'b1);
    endtask

    task automatic test_pair_swap();
        // a full pair, an unpaired sample dropped at block end, then another pair
        set_format(5'd16, 5'd16, 1'b1, 1'b1, 5'd1, 1'b1);
        send_elem(16'h1111, 1'b0);
        send_elem(16'h2222, 1'b0);
        send_elem(16'h3333, 1'b1);
        send_elem(16'h4444, 1'b0);
        send_elem(16'h5555, 1'b1);
    endtask

    task automatic test_held_across_swap_off();
        set_format(5'd16, 5'd16, 1'b1, 1'b1, 5'd1, 1'b1);
        send_elem(16'hAAAA, 1'b0);
        drain_stream();
        write_reg(CFG_SWAP_PAIRS, 5'd0);
        send_elem(16'hBBBB, 1'b0);
        drain_stream();
        write_reg(CFG_SWAP_PAIRS, 5'd1);
        send_elem(16'hCCCC, 1'b1);
    endtask

    task automatic pick_random_format();
        int                    kind;
        logic [CFG_DATA_W-1:0] sb;
        logic [CFG_DATA_W-1:0] ob;
        logic [CFG_DATA_W-1:0] st;
        kind = $urandom_range(0, 9);
        if (kind <= 2) begin
            sb = CFG_DATA_W'($urandom_range(0, 8));
            ob = CFG_DATA_W'($urandom_range(9, 31));
        end else if (kind == 3) begin
            sb = CFG_DATA_W'($urandom_range(0, 8));
            ob = CFG_DATA_W'($urandom_range(0, 8));
        end else if (kind <= 6) begin
            sb = CFG_DATA_W'($urandom_range(9, 31));
            ob = CFG_DATA_W'($urandom_range(9, 31));
        end else if (kind == 7) begin
            sb = CFG_DATA_W'($urandom_range(9, 31));
            ob = CFG_DATA_W'($urandom_range(0, 8));
        end else begin
            sb = CFG_DATA_W'($urandom_range(0, 31));
            ob = CFG_DATA_W'($urandom_range(0, 31));
        end
        st = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 31))
                                         : CFG_DATA_W'($urandom_range(1, 3));
        set_format(sb, ob, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), st,
                   1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_stream(input int settings, input int per_setting);
        int                  left_in_block;
        logic [SAMPLE_W-1:0] raw;
        logic                last_flag;
        for (int s = 0; s < settings; s++) begin
            pick_random_format();
            left_in_block = 0;
            for (int n = 0; n < per_setting; n++) begin
                if (left_in_block == 0) begin
                    left_in_block = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
                                                                : $urandom_range(1, 8);
                end
                case ($urandom_range(0, 15))
                    0:       raw = 16'h0000;
                    1:       raw = 16'hFFFF;
                    2:       raw = 16'h8000;
                    3:       raw = 16'h7FFF;
                    default: raw = SAMPLE_W'($urandom_range(0, 65535));
                endcase
                left_in_block--;
                // mostly well-formed blocks, now and then a block cut short
                last_flag = (left_in_block == 0) || ($urandom_range(0, 31) == 0);
                if (last_flag) begin
                    left_in_block = 0;
                end
                send_elem(raw, last_flag);
            end
        end
    endtask

    task automatic test_backpressure();
        set_format(5'd16, 5'd16, 1'b0, 1'b1, 5'd1, 1'b1);
        hold_left = 300;
        for (int n = 0; n < 60; n++) begin
            send_elem(SAMPLE_W'($urandom_range(0, 65535)), (n % 20) == 19);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_raw_sample    = '0;
        i_last_in_block = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_SOURCE_BITS;
        i_cfg_data      = '0;
        fmt_src_bits    = 5'd16;
        fmt_out_bits    = 5'd16;
        fmt_src_signed  = 1'b1;
        fmt_out_signed  = 1'b1;
        fmt_step        = 5'd1;
        fmt_swap        = 1'b0;
        step_pos        = 0;
        held_sample     = '0;
        held_ok         = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct = 10;
        rx_idle_pct  = 69;
        test_reset_defaults();
        test_narrow_to_wide();
        test_narrow_to_narrow();
        test_wide_shift();
        test_clamped_fields();
        test_bad_mode();
        test_pair_swap();
        test_held_across_swap_off();
        test_random_stream(11, 50);

        src_idle_pct = 69;
        rx_idle_pct  = 10;
        test_random_stream(11, 50);

        src_idle_pct = 0;
        rx_idle_pct  = 0;
        test_random_stream(11, 50);
        test_backpressure();

        drain_stream();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Run limit
    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
